### hw/rtl/plst_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps
package plst_pkg;

    localparam int DEPTH = 32;
    localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int CMPW  = 7;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_WRITE  = 3'd4;
    localparam logic [2:0] CMD_DUMP   = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [1:0] STAT_BADPOS    = 2'd3;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INSERT,
        CO_DELETE,
        CO_WRITE,
        CO_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDXW-1:0]   slot;
        logic [IDXW-1:0]   last;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

### hw/rtl/plst_cell.sv
// One list entry cell: holds a word and shifts with its neighbors.
`timescale 1ns / 1ps
module plst_cell (
    input  logic                       i_clk,
    input  logic [plst_pkg::IDXW-1:0]  i_index,
    input  plst_pkg::t_cell_ctl        i_ctl,
    input  logic [31:0]                i_new_value,
    input  logic [31:0]                i_left,
    input  logic [31:0]                i_right,
    input  logic [31:0]                i_head,
    output logic [31:0]                o_value,
    output logic [31:0]                o_sel_value
);

    logic [31:0] r_value;
    logic [31:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            plst_pkg::CO_INSERT: begin
                if (i_index > i_ctl.slot) begin
                    n_value = i_left;
                end else if (i_index == i_ctl.slot) begin
                    n_value = i_new_value;
                end
            end
            plst_pkg::CO_DELETE: begin
                if (i_index >= i_ctl.slot) begin
                    n_value = i_right;
                end
            end
            plst_pkg::CO_WRITE: begin
                if (i_index == i_ctl.slot) begin
                    n_value = i_new_value;
                end
            end
            plst_pkg::CO_ROTATE: begin
                if (i_index < i_ctl.last) begin
                    n_value = i_right;
                end else if (i_index == i_ctl.last) begin
                    n_value = i_head;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    assign o_sel_value = (i_index == i_ctl.slot) ? r_value : 32'd0;

endmodule

### hw/rtl/plst_chain.sv
// Row of entry cells with neighbor links, head tap and slot readout.
`timescale 1ns / 1ps
module plst_chain (
    input  logic                 i_clk,
    input  plst_pkg::t_cell_ctl  i_ctl,
    input  logic [31:0]          i_new_value,
    output logic [31:0]          o_head,
    output logic [31:0]          o_sel_value
);

    logic [31:0] w_val [plst_pkg::DEPTH];
    logic [31:0] w_sel [plst_pkg::DEPTH];

    for (genvar g = 0; g < plst_pkg::DEPTH; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_new_value;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == plst_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        plst_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (plst_pkg::IDXW'(g)),
            .i_ctl       (i_ctl),
            .i_new_value (i_new_value),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_head      (w_val[0]),
            .o_value     (w_val[g]),
            .o_sel_value (w_sel[g])
        );
    end

    // only the addressed cell drives nonzero
    always_comb begin
        o_sel_value = 32'd0;
        for (int k = 0; k < plst_pkg::DEPTH; k++) begin
            o_sel_value = o_sel_value | w_sel[k];
        end
    end

    assign o_head = w_val[0];

endmodule

### hw/rtl/positional_list_store_core.sv
// Top level of the positional list store: command decode, dump sequencer, output register.
// Each accepted command writes its first result straight into the output register.
// Clear, insert, delete, read and overwrite give a single result each; a dump of N
//   entries gives N results, one result per cycle while the output is not stalled, from the rotation of the cell row.
// Reset (synchronous, i_rst_n low): list length zero, sequencer idle, output empty.
//   Entry words are not cleared; only entries below the length are ever read.
`timescale 1ns / 1ps
module positional_list_store_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command channel
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [2:0]   i_cmd,
    input  logic [5:0]   i_slot_number,
    input  logic signed [31:0] i_new_value,
    // result channel
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic signed [31:0] o_read_value,
    output logic [1:0]   o_status,
    output logic [5:0]   o_list_length,
    output logic         o_last_of_run
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    plst_pkg::t_state              r_state, n_state;
    logic [plst_pkg::CNTW-1:0]     r_count, n_count;
    logic [plst_pkg::IDXW-1:0]     r_idx, n_idx;

    // output register (payload has no reset)
    logic                          r_out_valid, n_out_valid;
    logic [31:0]                   r_read_value, n_read_value;
    logic [1:0]                    r_status, n_status;
    logic [5:0]                    r_list_length, n_list_length;
    logic                          r_last, n_last;

    // cell row
    plst_pkg::t_cell_ctl           w_ctl;
    logic [31:0]                   w_head;
    logic [31:0]                   w_sel_value;

    logic                          w_out_free;
    logic                          w_in_accept;

    // position checks, all at a common width
    logic [plst_pkg::CMPW-1:0]     w_pos;
    logic [plst_pkg::CMPW-1:0]     w_cnt;
    logic                          w_pos_zero;
    logic                          w_pos_in_list;   // 1..count
    logic                          w_pos_in_ins;    // 1..count+1
    logic                          w_full;
    logic                          w_empty;
    logic [plst_pkg::IDXW-1:0]     w_slot;
    logic [plst_pkg::IDXW-1:0]     w_last_idx;

    // Output slot is free when empty or its transfer completes this edge.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == plst_pkg::ST_IDLE) && w_out_free);
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_pos         = plst_pkg::CMPW'(i_slot_number);
    assign w_cnt         = plst_pkg::CMPW'(r_count);
    assign w_pos_zero    = (w_pos == '0);
    assign w_pos_in_list = !w_pos_zero && (w_pos <= w_cnt);
    assign w_pos_in_ins  = !w_pos_zero && (w_pos <= w_cnt + plst_pkg::CMPW'(1));
    assign w_full        = (r_count >= plst_pkg::CNTW'(plst_pkg::DEPTH));
    assign w_empty       = (r_count == '0);
    // only meaningful when the position was checked valid
    assign w_slot        = plst_pkg::IDXW'(w_pos - plst_pkg::CMPW'(1));
    assign w_last_idx    = plst_pkg::IDXW'(r_count - plst_pkg::CNTW'(1));

    // ---------------------------------------------------------------
    // Next state, cell control and result
    // ---------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && i_out_stall;
        n_read_value  = r_read_value;
        n_status      = r_status;
        n_list_length = r_list_length;
        n_last        = r_last;
        w_ctl.op      = plst_pkg::CO_HOLD;
        w_ctl.slot    = w_slot;
        w_ctl.last    = w_last_idx;

        case (r_state)
            plst_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_out_valid  = 1'b1;
                    n_read_value = 32'd0;
                    n_status     = plst_pkg::STAT_OK;
                    n_last       = 1'b1;
                    case (i_cmd)
                        plst_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        plst_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_status = plst_pkg::STAT_OVERFLOW;
                            end else if (!w_pos_in_ins) begin
                                n_status = plst_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op = plst_pkg::CO_INSERT;
                                n_count  = r_count + plst_pkg::CNTW'(1);
                            end
                        end
                        plst_pkg::CMD_DELETE: begin
                            if (w_empty) begin
                                n_status = plst_pkg::STAT_UNDERFLOW;
                            end else if (!w_pos_in_list) begin
                                n_status = plst_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op = plst_pkg::CO_DELETE;
                                n_count  = r_count - plst_pkg::CNTW'(1);
                            end
                        end
                        plst_pkg::CMD_READ: begin
                            if (!w_pos_in_list) begin
                                n_status = plst_pkg::STAT_BADPOS;
                            end else begin
                                n_read_value = w_sel_value;
                            end
                        end
                        plst_pkg::CMD_WRITE: begin
                            if (!w_pos_in_list) begin
                                n_status = plst_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op = plst_pkg::CO_WRITE;
                            end
                        end
                        plst_pkg::CMD_DUMP: begin
                            if (w_empty) begin
                                n_status = plst_pkg::STAT_UNDERFLOW;
                            end else begin
                                // first entry leaves now; rest follow one per cycle while the output is not stalled
                                w_ctl.op     = plst_pkg::CO_ROTATE;
                                n_read_value = w_head;
                                n_last       = (r_count == plst_pkg::CNTW'(1));
                                n_idx        = plst_pkg::IDXW'(1);
                                if (r_count != plst_pkg::CNTW'(1)) begin
                                    n_state = plst_pkg::ST_DUMP;
                                end
                            end
                        end
                        default: begin
                            // unused codes: plain ok, nothing changes
                        end
                    endcase
                    n_list_length = 6'(n_count);
                end
            end
            plst_pkg::ST_DUMP: begin
                if (w_out_free) begin
                    // rotate the live part of the row; head emerges in order
                    w_ctl.op      = plst_pkg::CO_ROTATE;
                    n_out_valid   = 1'b1;
                    n_read_value  = w_head;
                    n_status      = plst_pkg::STAT_OK;
                    n_list_length = 6'(r_count);
                    n_last        = (r_idx == w_last_idx);
                    n_idx         = r_idx + plst_pkg::IDXW'(1);
                    if (r_idx == w_last_idx) begin
                        n_state = plst_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = plst_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plst_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value  <= n_read_value;
        r_status      <= n_status;
        r_list_length <= n_list_length;
        r_last        <= n_last;
    end

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    plst_chain u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_new_value (i_new_value),
        .o_head      (w_head),
        .o_sel_value (w_sel_value)
    );

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_list_length = r_list_length;
    assign o_last_of_run = r_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plst_pkg::CNTW'(plst_pkg::DEPTH))
        else $error("list length above depth");

    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plst_pkg::ST_DUMP) |-> (r_count != '0) && (r_idx <= w_last_idx))
        else $error("dump sequencer outside live entries");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == plst_pkg::ST_DUMP))
        else $error("non-final result without dump in progress");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != plst_pkg::STAT_OK)) |-> (r_read_value == 32'd0))
        else $error("error result carries data");

endmodule

### sim/tb_positional_list_store_core.sv
// Testbench for positional_list_store_core: directed table, random command mix, list predictor.
`timescale 1ns / 1ps
module tb_positional_list_store_core;
    import plst_pkg::*;

    // Spare command codes; the core answers them with a plain ok and leaves the list alone.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int WORK_ITEMS  = 330;
    // Worst case is every transfer a full dump with every result stalled for the longest gap
    // that pick_gap can give, over 330 transfers; the limit sits well above that.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 8;

    // One result transfer as it shows up on the output side.
    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [5:0]         length;
        logic               last;
    } t_list_reply;

    // One command; typed rows carry the single reply read straight off the spec.
    typedef struct {
        logic [2:0]  cmd;
        logic [5:0]  slot;
        logic [31:0] value;
        bit          typed;
        logic [31:0] exp_value;
        logic [1:0]  exp_status;
        logic [5:0]  exp_len;
    } t_cmd_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [2:0]         i_cmd         = '0;
    logic [5:0]         i_slot_number = '0;
    logic signed [31:0] i_new_value   = '0;
    logic               i_out_stall   = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_read_value;
    logic [1:0]         o_status;
    logic [5:0]         o_list_length;
    logic               o_last_of_run;

    positional_list_store_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_slot_number (i_slot_number),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_list_length (o_list_length),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the list, advanced at every accepted command transfer.
    logic signed [31:0] list_words [DEPTH];
    int                 list_len = 0;
    t_list_reply        burst[$];     // replies of the command just predicted
    t_list_reply        reply_q[$];   // replies not yet seen on the output

    int error_count = 0;
    int work_count  = 0;
    bit calm        = 1'b0;           // no gaps and no stalls while set
    int stall_left  = 0;

    task automatic report_fail(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Mostly short gaps, a few long ones, none at all in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Random words with the sign extremes, zero and all-ones showing up often.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 32'h8000_0000;
        if (r < 16) return 32'h7FFF_FFFF;
        if (r < 20) return 32'h0000_0000;
        if (r < 24) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // A position that names a present entry; on an empty list anything goes.
    function automatic logic [5:0] held_slot();
        if (list_len == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, list_len));
    endfunction

    function automatic void push_reply(input logic [31:0] v, input logic [1:0] st,
                                       input logic lst);
        t_list_reply r;
        r.value  = v;
        r.status = st;
        r.length = list_len[5:0];
        r.last   = lst;
        burst.push_back(r);
    endfunction

    // Applies one command to the shadow list and collects the replies it causes.
    // Full is checked before position on insert, empty before position on delete.
    task automatic step_list(input logic [2:0] c, input logic [5:0] s,
                             input logic [31:0] v);
        int p;
        int k;
        p = s;
        burst.delete();
        case (c)
            CMD_CLEAR: begin
                list_len = 0;
                push_reply('0, STAT_OK, 1'b1);
            end
            CMD_INSERT: begin
                if (list_len >= DEPTH) begin
                    push_reply('0, STAT_OVERFLOW, 1'b1);
                end else if (p == 0 || p > list_len + 1) begin
                    push_reply('0, STAT_BADPOS, 1'b1);
                end else begin
                    for (k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
                    list_words[p-1] = v;
                    list_len++;
                    push_reply('0, STAT_OK, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (list_len == 0) begin
                    push_reply('0, STAT_UNDERFLOW, 1'b1);
                end else if (p == 0 || p > list_len) begin
                    push_reply('0, STAT_BADPOS, 1'b1);
                end else begin
                    for (k = p - 1; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
                    list_len--;
                    push_reply('0, STAT_OK, 1'b1);
                end
            end
            CMD_READ: begin
                if (p == 0 || p > list_len) push_reply('0, STAT_BADPOS, 1'b1);
                else push_reply(list_words[p-1], STAT_OK, 1'b1);
            end
            CMD_WRITE: begin
                if (p == 0 || p > list_len) begin
                    push_reply('0, STAT_BADPOS, 1'b1);
                end else begin
                    list_words[p-1] = v;
                    push_reply('0, STAT_OK, 1'b1);
                end
            end
            CMD_DUMP: begin
                if (list_len == 0) begin
                    push_reply('0, STAT_UNDERFLOW, 1'b1);
                end else begin
                    for (k = 0; k < list_len; k++)
                        push_reply(list_words[k], STAT_OK, k == list_len - 1);
                end
            end
            default: push_reply('0, STAT_OK, 1'b1);
        endcase
    endtask

    // Drives one command transfer after a random gap, holds it through stalls, and
    // books its replies at the edge that takes it. Valid stays high between
    // back-to-back transfers, so it is never lowered and raised in one step.
    task automatic send_row(input t_cmd_row row);
        int gap;
        t_list_reply r;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= row.cmd;
        i_slot_number <= row.slot;
        i_new_value   <= row.value;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        step_list(row.cmd, row.slot, row.value);
        if (row.typed) begin
            r.value  = row.exp_value;
            r.status = row.exp_status;
            r.length = row.exp_len;
            r.last   = 1'b1;
            burst.delete();
            burst.push_back(r);
        end
        foreach (burst[k]) reply_q.push_back(burst[k]);
        if (row.cmd != CMD_SPARE_6 && row.cmd != CMD_SPARE_7) work_count++;
    endtask

    task automatic send_cmd(input logic [2:0] c, input logic [5:0] s, input logic [31:0] v);
        t_cmd_row row;
        row = '{c, s, v, 1'b0, '0, '0, '0};
        send_row(row);
    endtask

    // Holds the command side off until every booked reply has come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    // Fill from empty to full at random positions, push against the top with any
    // position, dump all 32 entries, then take a few back out.
    task automatic run_fill();
        int k;
        send_cmd(CMD_CLEAR, 6'($urandom_range(0, 63)), pick_value());
        while (list_len < DEPTH)
            send_cmd(CMD_INSERT, 6'($urandom_range(1, list_len + 1)), pick_value());
        send_cmd(CMD_INSERT, 6'($urandom_range(0, 63)), pick_value());
        send_cmd(CMD_INSERT, 6'd1, pick_value());
        send_cmd(CMD_DUMP, 6'($urandom_range(0, 63)), pick_value());
        for (k = 0; k < 3; k++) begin
            send_cmd(CMD_READ, held_slot(), pick_value());
            send_cmd(CMD_DELETE, held_slot(), pick_value());
        end
        settle();
    endtask

    // Mostly well-formed commands on a small list, with some raw noise mixed in.
    task automatic run_churn();
        int k;
        int r;
        if ($urandom_range(0, 2) == 0)
            send_cmd(CMD_CLEAR, 6'($urandom_range(0, 63)), pick_value());
        for (k = 0; k < 20; k++) begin
            r = $urandom_range(0, 99);
            if (r < 28)
                send_cmd(CMD_INSERT, 6'($urandom_range(1, list_len + 1)), pick_value());
            else if (r < 46) send_cmd(CMD_DELETE, held_slot(), pick_value());
            else if (r < 60) send_cmd(CMD_READ, held_slot(), pick_value());
            else if (r < 74) send_cmd(CMD_WRITE, held_slot(), pick_value());
            else if (r < 80) send_cmd(CMD_DUMP, 6'($urandom_range(0, 63)), pick_value());
            else if (r < 82) send_cmd(CMD_CLEAR, 6'($urandom_range(0, 63)), pick_value());
            else send_cmd(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom);
        end
    endtask

    // Output stall: bursts of random length, released during calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left  = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else begin
            stall_left = pick_gap();
            i_out_stall <= (stall_left != 0);
        end
    end

    // Every result transfer is matched against the oldest booked reply.
    always @(posedge i_clk) begin
        t_list_reply e;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (reply_q.size() == 0) begin
                report_fail($sformatf("unexpected result value=%h status=%0d len=%0d",
                                      o_read_value, o_status, o_list_length));
            end else begin
                e = reply_q.pop_front();
                if (o_read_value !== e.value)
                    report_fail($sformatf("read_value %h, want %h", o_read_value, e.value));
                if (o_status !== e.status)
                    report_fail($sformatf("status %0d, want %0d", o_status, e.status));
                if (o_list_length !== e.length)
                    report_fail($sformatf("list_length %0d, want %0d", o_list_length, e.length));
                if (o_last_of_run !== e.last)
                    report_fail($sformatf("last_of_run %0d, want %0d", o_last_of_run, e.last));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_cmd_row directed_rows [25];
        int idx;
        foreach (list_words[k]) list_words[k] = '0;
        // Rows on an empty list come first, then the two sign extremes; the untyped
        // rows (a shifting insert, a delete and the non-empty dumps) fall to the predictor.
        directed_rows = '{
            '{CMD_READ,    6'd1,  32'h0,         1'b1, 32'h0,         STAT_BADPOS,    6'd0},
            '{CMD_DELETE,  6'd1,  32'h0,         1'b1, 32'h0,         STAT_UNDERFLOW, 6'd0},
            '{CMD_DUMP,    6'd0,  32'h0,         1'b1, 32'h0,         STAT_UNDERFLOW, 6'd0},
            '{CMD_SPARE_6, 6'd5,  32'h1234_5678, 1'b1, 32'h0,         STAT_OK,        6'd0},
            '{CMD_INSERT,  6'd0,  32'h1,         1'b1, 32'h0,         STAT_BADPOS,    6'd0},
            '{CMD_INSERT,  6'd2,  32'h1,         1'b1, 32'h0,         STAT_BADPOS,    6'd0},
            '{CMD_WRITE,   6'd1,  32'h9,         1'b1, 32'h0,         STAT_BADPOS,    6'd0},
            '{CMD_INSERT,  6'd1,  32'h7FFF_FFFF, 1'b1, 32'h0,         STAT_OK,        6'd1},
            '{CMD_INSERT,  6'd1,  32'h8000_0000, 1'b1, 32'h0,         STAT_OK,        6'd2},
            '{CMD_READ,    6'd1,  32'h0,         1'b1, 32'h8000_0000, STAT_OK,        6'd2},
            '{CMD_READ,    6'd2,  32'h0,         1'b1, 32'h7FFF_FFFF, STAT_OK,        6'd2},
            '{CMD_READ,    6'd3,  32'h0,         1'b1, 32'h0,         STAT_BADPOS,    6'd2},
            '{CMD_READ,    6'd63, 32'h0,         1'b1, 32'h0,         STAT_BADPOS,    6'd2},
            '{CMD_WRITE,   6'd2,  32'hFFFF_FFFF, 1'b1, 32'h0,         STAT_OK,        6'd2},
            '{CMD_READ,    6'd2,  32'h0,         1'b1, 32'hFFFF_FFFF, STAT_OK,        6'd2},
            '{CMD_INSERT,  6'd3,  32'h5,         1'b1, 32'h0,         STAT_OK,        6'd3},
            '{CMD_INSERT,  6'd2,  32'hA5A5_A5A5, 1'b0, 32'h0,         STAT_OK,        6'd0},
            '{CMD_DUMP,    6'd17, 32'h0,         1'b0, 32'h0,         STAT_OK,        6'd0},
            '{CMD_DELETE,  6'd0,  32'h0,         1'b1, 32'h0,         STAT_BADPOS,    6'd4},
            '{CMD_DELETE,  6'd5,  32'h0,         1'b1, 32'h0,         STAT_BADPOS,    6'd4},
            '{CMD_DELETE,  6'd1,  32'h0,         1'b0, 32'h0,         STAT_OK,        6'd0},
            '{CMD_SPARE_7, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0,         STAT_OK,        6'd3},
            '{CMD_DUMP,    6'd0,  32'h0,         1'b0, 32'h0,         STAT_OK,        6'd0},
            '{CMD_CLEAR,   6'd42, 32'hDEAD_BEEF, 1'b1, 32'h0,         STAT_OK,        6'd0},
            '{CMD_DUMP,    6'd1,  32'h0,         1'b1, 32'h0,         STAT_UNDERFLOW, 6'd0}
        };

        // Reset held low from the start, released at an edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < 25; idx++) send_row(directed_rows[idx]);
        settle();

        // First random block always fills the list so that the full and
        // 32-entry dump cases are reached; after that fills are occasional.
        run_fill();
        while (work_count < WORK_ITEMS) begin
            if ($urandom_range(0, 9) < 2) begin
                calm = 1'b0;
                run_fill();
            end else begin
                calm = ($urandom_range(0, 3) == 0);
                run_churn();
            end
        end
        calm = 1'b0;

        // Drain, then leave room for any stray result before the verdict.
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
